### rtl/core/mgtd_pkg.sv
// Shared types and constants for the multichannel gesture threshold detector.
// No dependencies; every module of the block imports this package.
package mgtd_pkg;

  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int TILT_LIMIT  = 2304;           // 9 m/s2 in 1/256 units
  localparam int MAG_W       = 12;
  localparam int THR_W       = 9;
  localparam int MIN_SPAN_W  = 16;
  localparam int WIN_W       = 12;
  localparam int YOFF_W      = 13;
  localparam int ACC_W       = 16;
  localparam int FRAC_BITS   = 8;              // threshold is in 1/256
  localparam int PROD_W      = THR_W + SAMPLE_BITS;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Item operations; the unnamed fourth code behaves as detect
  typedef enum logic [1:0] {
    OP_DETECT  = 2'd0,
    OP_REST    = 2'd1,
    OP_GESTURE = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_MIN_SPAN    = 2'd1,
    REG_TILT_WINDOW = 2'd2,
    REG_Y_OFFSET    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [15:0]             sample_0;
    logic [15:0]             sample_1;
    logic [15:0]             sample_2;
    logic [15:0]             sample_3;
    logic [15:0]             sample_4;
    logic [15:0]             sample_5;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
  } in_item_t;

  typedef struct packed {
    logic             gesture;
    logic [5:0]       channel_mask;
    logic             x_negative;
    logic [MAG_W-1:0] x_magnitude;
    logic             y_negative;
    logic [MAG_W-1:0] y_magnitude;
  } out_item_t;

  // Per-lane status toward the merge stage
  typedef struct packed {
    logic used;   // channel in the mask after this item
    logic pass;   // channel meets threshold (or is not used)
  } lane_stat_t;

endpackage

### rtl/core/multichannel_gesture_threshold_detector.sv
// Top level of the multichannel gesture threshold detector: config registers,
// channel lanes, tilt units, merge stage and output skid buffer.
// Depends on mgtd_pkg, mgtd_lane and mgtd_tilt.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one frame per transfer:
//   an operation code, six sensor samples and two accelerometer axes.
//   Rest capture and gesture capture update the per-lane calibration; detect
//   compares all six lanes in parallel and the merge stage ANDs their results
//   with the tilt window test.
//   Every transfer yields exactly one result on out_valid/out_stall/out_data,
//   held in the output register or the skid entry. Throughput is one frame per
//   cycle while in_stall is low, with a combinational 9x16 multiply and compare per lane.
//   The output register is backed by a one-entry skid stage, so a frame is
//   still taken while a result waits; in_stall rises only when both are full.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   taken and must only occur while the block is idle.
//   Synchronous active-low reset clears calibration, the channel mask and the
//   gesture flag, loads the register defaults and empties the output side.
module multichannel_gesture_threshold_detector import mgtd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [THR_W-1:0]          threshold_r;
  logic [MIN_SPAN_W-1:0]     min_span_r;
  logic [WIN_W-1:0]          tilt_window_r;
  logic signed [YOFF_W-1:0]  y_offset_r;

  logic       gesture_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       skid_valid_r;
  out_item_t  skid_data_r;

  logic       in_acc;
  logic       out_take;
  logic       cap_rest;
  logic       cap_gesture;
  logic       is_detect;
  logic       tilt_ok;
  logic       gesture_nxt;
  sample_t    samp [CHANNELS];
  lane_stat_t stat [CHANNELS];
  logic [CHANNELS-1:0] chan_mask;
  logic [CHANNELS-1:0] pass_vec;
  logic       x_neg;
  logic       y_neg;
  logic [MAG_W-1:0] x_mag;
  logic [MAG_W-1:0] y_mag;
  out_item_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THR_W'(128);
      min_span_r    <= MIN_SPAN_W'(100);
      tilt_window_r <= WIN_W'(768);
      y_offset_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   threshold_r   <= cfg_data[THR_W-1:0];
        REG_MIN_SPAN:    min_span_r    <= cfg_data[MIN_SPAN_W-1:0];
        REG_TILT_WINDOW: tilt_window_r <= cfg_data[WIN_W-1:0];
        REG_Y_OFFSET:    y_offset_r    <= cfg_data[YOFF_W-1:0];
      endcase
    end
  end

  // Input transfer decode
  assign in_acc      = in_valid & ~in_stall;
  assign cap_rest    = in_acc & (in_data.operation == OP_REST);
  assign cap_gesture = in_acc & (in_data.operation == OP_GESTURE);
  assign is_detect   = (in_data.operation != OP_REST) &&
                       (in_data.operation != OP_GESTURE);

  assign samp[0] = in_data.sample_0[SAMPLE_BITS-1:0];
  assign samp[1] = in_data.sample_1[SAMPLE_BITS-1:0];
  assign samp[2] = in_data.sample_2[SAMPLE_BITS-1:0];
  assign samp[3] = in_data.sample_3[SAMPLE_BITS-1:0];
  assign samp[4] = in_data.sample_4[SAMPLE_BITS-1:0];
  assign samp[5] = in_data.sample_5[SAMPLE_BITS-1:0];

  // Channel lanes
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    mgtd_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .cap_rest    (cap_rest),
      .cap_gesture (cap_gesture),
      .sample      (samp[i]),
      .min_span    (min_span_r),
      .threshold   (threshold_r),
      .stat        (stat[i])
    );
    assign chan_mask[i] = stat[i].used;
    assign pass_vec[i]  = stat[i].pass;
  end

  // Tilt axes
  mgtd_tilt u_tilt_x (
    .accel     (in_data.accel_x),
    .offset    ('0),
    .negative  (x_neg),
    .magnitude (x_mag)
  );

  mgtd_tilt u_tilt_y (
    .accel     (in_data.accel_y),
    .offset    (y_offset_r),
    .negative  (y_neg),
    .magnitude (y_mag)
  );

  // Merge: tilt window gate and all-lanes-pass
  always_comb begin
    tilt_ok     = (WIN_W'(x_mag) <= tilt_window_r) && (WIN_W'(y_mag) <= tilt_window_r);
    gesture_nxt = is_detect ? (tilt_ok & (&pass_vec)) : gesture_r;
    res.gesture      = gesture_nxt;
    res.channel_mask = 6'(chan_mask);
    res.x_negative   = x_neg;
    res.x_magnitude  = x_mag;
    res.y_negative   = y_neg;
    res.y_magnitude  = y_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gesture_r <= 1'b0;
    end else if (in_acc) begin
      gesture_r <= gesture_nxt;
    end
  end

  // Output register with one-entry skid stage
  assign out_take = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_capture_keeps_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_detect) |=> $stable(gesture_r))
    else $error("gesture flag changed on a capture transfer");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_valid_r && !skid_valid_r) |=>
      (out_valid_r && out_data_r.channel_mask == $past(res.channel_mask)))
    else $error("result of accepted frame not in output register");

endmodule

### rtl/core/mgtd_lane.sv
// One sensor channel lane: calibration storage, capture and threshold test.
// Depends on mgtd_pkg.
module mgtd_lane import mgtd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cap_rest,
  input  logic                  cap_gesture,
  input  sample_t               sample,
  input  logic [MIN_SPAN_W-1:0] min_span,
  input  logic [THR_W-1:0]      threshold,
  output lane_stat_t            stat
);

  sample_t rest_r;
  sample_t active_r;
  sample_t span_r;
  logic    used_r;

  sample_t span_nxt;
  logic    used_nxt;
  sample_t lo;
  sample_t hi;
  sample_t clamped;
  sample_t rest_dist;
  logic [PROD_W-1:0] dist_scaled;
  logic [PROD_W-1:0] thr_span;

  // Span against the stored rest level, for gesture capture
  always_comb begin
    span_nxt = (sample > rest_r) ? sample - rest_r : rest_r - sample;
    used_nxt = MIN_SPAN_W'(span_nxt) >= min_span;
  end

  // Clamp into the calibrated range, then distance from rest
  always_comb begin
    lo = (rest_r < active_r) ? rest_r : active_r;
    hi = (rest_r < active_r) ? active_r : rest_r;
    if (sample > hi) begin
      clamped = hi;
    end else if (sample < lo) begin
      clamped = lo;
    end else begin
      clamped = sample;
    end
    rest_dist   = (clamped > rest_r) ? clamped - rest_r : rest_r - clamped;
    dist_scaled = PROD_W'(rest_dist) << FRAC_BITS;
    thr_span    = PROD_W'(threshold) * PROD_W'(span_r);
  end

  assign stat.used = cap_gesture ? used_nxt : used_r;
  assign stat.pass = ~used_r | (dist_scaled >= thr_span);

  // Calibration storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r   <= '0;
      active_r <= '0;
      span_r   <= '0;
      used_r   <= 1'b0;
    end else begin
      if (cap_rest) begin
        rest_r <= sample;
      end
      if (cap_gesture) begin
        active_r <= sample;
        span_r   <= span_nxt;
        used_r   <= used_nxt;
      end
    end
  end

endmodule

### rtl/core/mgtd_tilt.sv
// Tilt axis conditioning: add offset, clamp to +-9 m/s2, split sign/magnitude.
// Depends on mgtd_pkg.
module mgtd_tilt import mgtd_pkg::*; (
  input  logic signed [ACC_W-1:0]  accel,
  input  logic signed [YOFF_W-1:0] offset,
  output logic                     negative,
  output logic [MAG_W-1:0]         magnitude
);

  localparam logic signed [ACC_W:0] LIM_POS = (ACC_W+1)'(TILT_LIMIT);
  localparam logic signed [ACC_W:0] LIM_NEG = -(ACC_W+1)'(TILT_LIMIT);

  logic signed [ACC_W:0]  sum;
  logic signed [MAG_W:0]  clamped;

  // Offset add and saturate
  always_comb begin
    sum = (ACC_W+1)'(accel) + (ACC_W+1)'(offset);
    if (sum > LIM_POS) begin
      clamped = (MAG_W+1)'(LIM_POS);
    end else if (sum < LIM_NEG) begin
      clamped = (MAG_W+1)'(LIM_NEG);
    end else begin
      clamped = (MAG_W+1)'(sum);
    end
    negative  = clamped[MAG_W];
    magnitude = negative ? MAG_W'(-clamped) : MAG_W'(clamped);
  end

endmodule

### tb/tb_multichannel_gesture_threshold_detector.sv
// Self-checking testbench for the multichannel gesture threshold detector.
// Drives frames and register writes and checks every result against a local predictor or a directed expected value.
// Depends on mgtd_pkg and the multichannel_gesture_threshold_detector RTL.
module tb_multichannel_gesture_threshold_detector;
  import mgtd_pkg::*;

  localparam logic [1:0] OP_ALT_DETECT = 2'd3;   // spare code, acts as detect
  localparam int         PHASES        = 6;
  localparam int         PHASE_FRAMES  = 305;
  localparam int         DRAIN_CYCLES  = 4;

  typedef struct {
    in_item_t  frame;
    bit        typed;
    out_item_t want;
  } table_row_t;

  typedef struct {
    bit        typed;
    out_item_t want;
  } typed_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor copy of the registers and calibration state
  logic [THR_W-1:0]        thr_cfg      = 9'd128;
  logic [MIN_SPAN_W-1:0]   span_min_cfg = 16'd100;
  logic [WIN_W-1:0]        win_cfg      = 12'd768;
  logic signed [YOFF_W-1:0] yoff_cfg    = '0;
  logic [SAMPLE_BITS-1:0]  rest_lvl [CHANNELS] = '{default: '0};
  logic [SAMPLE_BITS-1:0]  act_lvl  [CHANNELS] = '{default: '0};
  logic [SAMPLE_BITS-1:0]  span_lvl [CHANNELS] = '{default: '0};
  logic [CHANNELS-1:0]     used_mask = '0;
  logic                    gesture_state = 1'b0;

  // Stimulus-side view of the calibration it has sent
  int gen_rest [CHANNELS] = '{default: 0};
  int gen_act  [CHANNELS] = '{default: 0};
  bit need_active = 1'b0;
  int seq_left    = 0;

  out_item_t     pending_results [$];
  typed_result_t typed_results   [$];
  table_row_t    directed_rows   [$];

  int mismatches   = 0;
  int result_count = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  multichannel_gesture_threshold_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int bound(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Register write as the block applies it: truncated to each register width
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (cfg_reg_t'(idx))
      REG_THRESHOLD:   thr_cfg      = d[THR_W-1:0];
      REG_MIN_SPAN:    span_min_cfg = d[MIN_SPAN_W-1:0];
      REG_TILT_WINDOW: win_cfg      = d[WIN_W-1:0];
      REG_Y_OFFSET:    yoff_cfg     = d[YOFF_W-1:0];
      default: ;
    endcase
  endfunction

  // Expected result of one frame; updates the calibration state
  function automatic out_item_t predict_frame(in_item_t fr);
    out_item_t              res;
    logic [SAMPLE_BITS-1:0] smp [CHANNELS];
    int                     ax, ay;
    int unsigned            xm, ym, lo, hi, v, rest_dist, rl;
    bit                     ok;
    smp = '{fr.sample_0, fr.sample_1, fr.sample_2, fr.sample_3, fr.sample_4, fr.sample_5};
    ax = bound(int'($signed(fr.accel_x)), -TILT_LIMIT, TILT_LIMIT);
    ay = bound(int'($signed(fr.accel_y)) + int'(yoff_cfg), -TILT_LIMIT, TILT_LIMIT);
    xm = (ax < 0) ? -ax : ax;
    ym = (ay < 0) ? -ay : ay;
    case (fr.operation)
      OP_REST: begin
        for (int i = 0; i < CHANNELS; i++) rest_lvl[i] = smp[i];
      end
      OP_GESTURE: begin
        used_mask = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          act_lvl[i]  = smp[i];
          span_lvl[i] = (smp[i] > rest_lvl[i]) ? smp[i] - rest_lvl[i] : rest_lvl[i] - smp[i];
          used_mask[i] = (span_lvl[i] >= span_min_cfg);
        end
      end
      default: begin
        // detect: tilt gate, then every used lane must reach the threshold
        ok = (xm <= win_cfg) && (ym <= win_cfg);
        for (int i = 0; i < CHANNELS; i++) begin
          if (ok && used_mask[i]) begin
            rl = rest_lvl[i];
            lo = (rest_lvl[i] < act_lvl[i]) ? rest_lvl[i] : act_lvl[i];
            hi = (rest_lvl[i] < act_lvl[i]) ? act_lvl[i] : rest_lvl[i];
            v  = smp[i];
            if (v > hi) v = hi;
            else if (v < lo) v = lo;
            rest_dist = (v > rl) ? v - rl : rl - v;
            if (rest_dist * 256 < int'(thr_cfg) * int'(span_lvl[i])) ok = 1'b0;
          end
        end
        gesture_state = ok;
      end
    endcase
    res.gesture      = gesture_state;
    res.channel_mask = used_mask;
    res.x_negative   = (ax < 0);
    res.x_magnitude  = xm[MAG_W-1:0];
    res.y_negative   = (ay < 0);
    res.y_magnitude  = ym[MAG_W-1:0];
    return res;
  endfunction

  // Random frame: rest capture, gesture capture, then mostly detects near the thresholds, with some noise frames
  function automatic in_item_t next_frame();
    in_item_t fr;
    int       lv [CHANNELS];
    int       r, k, span, dir, need, win, yo, bias;
    fr   = '0;
    r    = $urandom_range(99);
    win  = int'(win_cfg);
    yo   = int'(yoff_cfg);
    k    = $urandom_range(9);
    if (k == 0) begin
      fr.accel_x = 16'($urandom);
      fr.accel_y = 16'($urandom);
    end else if (k == 1) begin
      fr.accel_x = 16'(bound(($urandom_range(1) ? win : -win) + int'($urandom_range(2)) - 1,
                             -32768, 32767));
      fr.accel_y = 16'(bound(-yo + ($urandom_range(1) ? win : -win) +
                             int'($urandom_range(2)) - 1, -32768, 32767));
    end else begin
      fr.accel_x = 16'(bound(int'($urandom_range(2 * win)) - win, -32768, 32767));
      fr.accel_y = 16'(bound(-yo + int'($urandom_range(2 * win)) - win, -32768, 32767));
    end
    if (need_active) begin
      // gesture capture with spans of zero, around min_span or random
      fr.operation = OP_GESTURE;
      need_active  = 1'b0;
      seq_left     = $urandom_range(12, 3);
      for (int i = 0; i < CHANNELS; i++) begin
        case ($urandom_range(5))
          0:       span = 0;
          1:       span = bound(int'(span_min_cfg) - 1, 0, 65535);
          2:       span = int'(span_min_cfg);
          3:       span = $urandom_range(2 * int'(span_min_cfg) + 16);
          default: span = $urandom_range(65535);
        endcase
        dir = $urandom_range(1) ? 1 : -1;
        if (gen_rest[i] + dir * span > 65535 || gen_rest[i] + dir * span < 0) dir = -dir;
        lv[i] = bound(gen_rest[i] + dir * span, 0, 65535);
      end
    end else if ((seq_left == 0 && r < 50) || r < 2) begin
      fr.operation = OP_REST;
      need_active  = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        case ($urandom_range(7))
          0:       lv[i] = 0;
          1:       lv[i] = 65535;
          default: lv[i] = $urandom_range(65535);
        endcase
      end
    end else if (r < 10) begin
      // noise: any code, any samples
      fr.operation = 2'($urandom);
      for (int i = 0; i < CHANNELS; i++) lv[i] = $urandom_range(65535);
    end else begin
      fr.operation = ($urandom_range(9) == 0) ? OP_ALT_DETECT : OP_DETECT;
      if (seq_left > 0) seq_left--;
      bias = $urandom_range(1);
      for (int i = 0; i < CHANNELS; i++) begin
        dir  = (gen_act[i] >= gen_rest[i]) ? 1 : -1;
        span = (gen_act[i] - gen_rest[i]) * dir;
        need = (int'(thr_cfg) * span + 255) / 256;
        k    = bias ? $urandom_range(5) : $urandom_range(11);
        case (k)
          0:       lv[i] = gen_act[i] + dir * int'($urandom_range(50));
          1, 2, 3, 4: lv[i] = gen_act[i];
          5, 6, 7: lv[i] = gen_rest[i] + dir * (need + int'($urandom_range(2)) - 1);
          8:       lv[i] = gen_rest[i] - dir * int'($urandom_range(100));
          9:       lv[i] = $urandom_range(65535);
          default: lv[i] = gen_rest[i] + dir * int'($urandom_range(span));
        endcase
        lv[i] = bound(lv[i], 0, 65535);
      end
    end
    fr.sample_0 = 16'(lv[0]);
    fr.sample_1 = 16'(lv[1]);
    fr.sample_2 = 16'(lv[2]);
    fr.sample_3 = 16'(lv[3]);
    fr.sample_4 = 16'(lv[4]);
    fr.sample_5 = 16'(lv[5]);
    if (fr.operation == OP_REST) gen_rest = lv;
    else if (fr.operation == OP_GESTURE) gen_act = lv;
    return fr;
  endfunction

  task automatic report_mismatch(string msg);
    $display("result %0d: %s", result_count, msg);
    mismatches++;
  endtask

  // Field-by-field compare against the oldest expectation
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending");
      return;
    end
    want = pending_results.pop_front();
    if (got.gesture !== want.gesture)
      report_mismatch($sformatf("gesture %0d, want %0d", got.gesture, want.gesture));
    if (got.channel_mask !== want.channel_mask)
      report_mismatch($sformatf("channel_mask %h, want %h", got.channel_mask,
                                want.channel_mask));
    if (got.x_negative !== want.x_negative)
      report_mismatch($sformatf("x_negative %0d, want %0d", got.x_negative, want.x_negative));
    if (got.x_magnitude !== want.x_magnitude)
      report_mismatch($sformatf("x_magnitude %0d, want %0d", got.x_magnitude,
                                want.x_magnitude));
    if (got.y_negative !== want.y_negative)
      report_mismatch($sformatf("y_negative %0d, want %0d", got.y_negative, want.y_negative));
    if (got.y_magnitude !== want.y_magnitude)
      report_mismatch($sformatf("y_magnitude %0d, want %0d", got.y_magnitude,
                                want.y_magnitude));
    result_count++;
  endtask

  // Transfer monitor: results, accepted frames, register writes
  always @(posedge clk) begin
    typed_result_t tr;
    out_item_t     predicted;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        predicted = predict_frame(in_data);
        tr = typed_results.pop_front();
        pending_results.push_back(tr.typed ? tr.want : predicted);
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic set_idling(int mode);
    case (mode)
      0:       begin tx_idle_pct = 34; rx_stall_pct = 45; end
      1:       begin tx_idle_pct = 45; rx_stall_pct = 34; end
      default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One frame transfer; valid stays high after acceptance for back-to-back frames
  task automatic send_frame(in_item_t fr, bit typed, out_item_t want, bit drain);
    if (drain) wait_results_done();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_results.push_back('{typed, want});
    in_valid <= 1'b1;
    in_data  <= fr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic add_row(logic [1:0] op, logic [95:0] smp, logic [15:0] ax, logic [15:0] ay,
                         bit typed = 1'b0, out_item_t want = '0);
    table_row_t row;
    row.frame = {op, smp, ax, ay};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  initial begin
    int ph_thr  [PHASES] = '{128, 0, 256, 511, 0, 200};
    int ph_span [PHASES] = '{100, 1, 65535, 0, 0, 0};
    int ph_win  [PHASES] = '{768, 0, 2304, 4095, 0, 2304};
    int ph_yoff [PHASES] = '{0, -2304, 2304, -4096, 0, 4095};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // Directed frames; typed results are {gesture, mask, xneg, xmag, yneg, ymag}
    add_row(OP_DETECT, '0, 16'd0, 16'd0, 1,
            {1'b1, 6'h00, 1'b0, 12'd0, 1'b0, 12'd0});
    add_row(OP_DETECT, '0, 16'h7FFF, 16'h8000, 1,
            {1'b0, 6'h00, 1'b0, 12'd2304, 1'b1, 12'd2304});
    add_row(OP_ALT_DETECT, '0, 16'h8000, 16'h7FFF, 1,
            {1'b0, 6'h00, 1'b1, 12'd2304, 1'b0, 12'd2304});
    add_row(OP_DETECT, '0, 16'hFFFF, 16'd1, 1,
            {1'b1, 6'h00, 1'b1, 12'd1, 1'b0, 12'd1});
    add_row(OP_DETECT, '0, 16'd768, 16'(-768), 1,
            {1'b1, 6'h00, 1'b0, 12'd768, 1'b1, 12'd768});
    add_row(OP_DETECT, '0, 16'd0, 16'd769, 1,
            {1'b0, 6'h00, 1'b0, 12'd0, 1'b0, 12'd769});
    // capture items keep the stored gesture flag
    add_row(OP_REST, {6{16'hFFFF}}, 16'd2305, 16'(-2305), 1,
            {1'b0, 6'h00, 1'b0, 12'd2304, 1'b1, 12'd2304});
    add_row(OP_GESTURE, '0, 16'd0, 16'd0, 1,
            {1'b0, 6'h3F, 1'b0, 12'd0, 1'b0, 12'd0});
    add_row(OP_DETECT, '0, 16'd0, 16'd0, 1,
            {1'b1, 6'h3F, 1'b0, 12'd0, 1'b0, 12'd0});
    add_row(OP_DETECT, {6{16'hFFFF}}, 16'd0, 16'd0, 1,
            {1'b0, 6'h3F, 1'b0, 12'd0, 1'b0, 12'd0});
    add_row(OP_DETECT, {6{16'd32767}}, 16'd0, 16'd0);
    add_row(OP_DETECT, {6{16'd32768}}, 16'd0, 16'd0);
    add_row(OP_DETECT, '0, 16'd0, 16'd1000, 1,
            {1'b0, 6'h3F, 1'b0, 12'd0, 1'b0, 12'd1000});
    // mixed calibration: spans just under, at and far above min_span, one zero span
    add_row(OP_REST, {16'd1000, 16'd0, 16'hFFFF, 16'd500, 16'h5555, 16'hAAAA},
            16'd0, 16'd0);
    add_row(OP_GESTURE, {16'd1099, 16'd100, 16'hFFFF, 16'd400, 16'hAAAA, 16'h5555},
            16'd0, 16'd0);
    // samples beyond the calibrated range are clamped
    add_row(OP_DETECT, {16'd0, 16'd200, 16'd0, 16'd0, 16'hFFFF, 16'h0000}, 16'd0, 16'd0);
    add_row(OP_DETECT, {16'd0, 16'd50, 16'd0, 16'd0, 16'hFFFF, 16'h0000}, 16'd0, 16'd0);
    add_row(OP_DETECT, {16'd0, 16'd49, 16'd0, 16'd0, 16'hFFFF, 16'h0000}, 16'd0, 16'd0);
    foreach (directed_rows[i])
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want, 1'b0);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      set_idling(p / 2);
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (p == 4) begin
        ph_thr[p]  = $urandom_range(256);
        ph_span[p] = $urandom_range(2000, 1);
        ph_win[p]  = $urandom_range(2304);
        ph_yoff[p] = int'($urandom_range(4608)) - 2304;
      end
      write_reg(REG_THRESHOLD, 16'(ph_thr[p]));
      write_reg(REG_MIN_SPAN, 16'(ph_span[p]));
      write_reg(REG_TILT_WINDOW, 16'(ph_win[p]));
      write_reg(REG_Y_OFFSET, 16'(ph_yoff[p]));
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_FRAMES; n++)
        send_frame(next_frame(), 1'b0, '0, $urandom_range(199) == 0);
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
